>>> rtl/wwrs_pkg.sv
`default_nettype none

package wwrs_pkg;

    // Table and relay sizing
    localparam int MAX_ENTRIES = 16;
    localparam int RELAY_COUNT = 16;
    localparam int MAX_RESULTS = 16;

    localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int EVQ_AW  = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
    localparam int EVC_W   = $clog2(MAX_RESULTS + 1);

    localparam logic [10:0] LAST_MINUTE = 11'd1439;
    localparam logic [7:0]  ID_LIMIT    = 8'hFF;

    // Command modes
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_UPSERT = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_SWITCH   = 3'd4;
    localparam logic [2:0] ST_NOIDS    = 3'd5;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  entry_id;
        logic [3:0]  relay_id;
        logic [6:0]  day_mask;
        logic [10:0] start_minute;
        logic [10:0] end_minute;
        logic        entry_enabled;
        logic [10:0] minute_of_day;
        logic [2:0]  weekday;
        logic [15:0] relay_auto_mask;
    } cmd_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] result_id;
        logic [3:0] switch_relay;
        logic       switch_on;
        logic       any_running;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [3:0]  relay;
        logic [6:0]  days;
        logic [10:0] start_minute;
        logic [10:0] end_minute;
        logic        enabled;
        logic        running;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [7:0] id;
        logic [3:0] relay;
        logic       on;
    } ev_t;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [ENTRY_W-1:0] wdata;
        logic [IDX_W-1:0]   raddr;
    } ram_req_t;

    typedef struct packed {
        logic push;
        logic pop;
        ev_t  ev;
    } evq_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIN,
        S_SHIFT,
        S_RESP,
        S_EMIT
    } state_t;

    function automatic logic relay_ok(input logic [3:0] relay, input logic [15:0] present);
        logic in_range;
        in_range = ({1'b0, relay} < 5'(RELAY_COUNT));
        return in_range && present[relay];
    endfunction

endpackage

`default_nettype wire

>>> rtl/wwrs_ram.sv
`default_nettype none

module wwrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/wwrs_evq.sv
`default_nettype none

module wwrs_evq
    import wwrs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire evq_req_t req,
    output ev_t           head
);

    ev_t               buf_mem [MAX_RESULTS];
    ev_t               head_reg;
    logic [EVQ_AW-1:0] wr_ptr_reg;
    logic [EVQ_AW-1:0] wr_ptr_next;
    logic [EVQ_AW-1:0] rd_ptr_reg;
    logic [EVQ_AW-1:0] rd_ptr_next;

    // advance a pointer with wrap at the queue depth
    function automatic logic [EVQ_AW-1:0] bump(input logic [EVQ_AW-1:0] p);
        return (p == EVQ_AW'(MAX_RESULTS - 1)) ? '0 : p + EVQ_AW'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = req.push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = req.pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            buf_mem[wr_ptr_reg] <= req.ev;
        end
        // read ahead at the next head so the entry is ready once popped
        head_reg <= buf_mem[rd_ptr_next];
    end

    assign head = head_reg;

endmodule

`default_nettype wire

>>> rtl/wwrs_ctrl.sv
`default_nettype none

module wwrs_ctrl
    import wwrs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire cmd_t               cmd,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output rsp_t                    rsp,
    input  wire logic               cfg_we,
    input  wire logic [15:0]        cfg_wdata,
    output ram_req_t                ram_req,
    input  wire logic [ENTRY_W-1:0] ram_rdata,
    output evq_req_t                evq_req,
    input  wire ev_t                evq_head
);

    state_t           state_reg, state_next;
    cmd_t             item_reg, item_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             pv_reg, pv_next;
    logic [IDX_W-1:0] p_idx_reg, p_idx_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             hit_run_reg, hit_run_next;
    logic [7:0]       maxid_reg, maxid_next;
    logic             run_all_reg, run_all_next;
    logic             run_excl_reg, run_excl_next;
    logic [EVC_W-1:0] ev_n_reg, ev_n_next;
    logic [EVC_W-1:0] em_reg, em_next;
    logic [2:0]       res_status_reg, res_status_next;
    logic [7:0]       res_id_reg, res_id_next;
    logic             res_any_reg, res_any_next;
    logic             out_valid_reg, out_valid_next;
    rsp_t             out_reg, out_next;
    logic [15:0]      present_reg;

    entry_t           rd_ent;
    entry_t           wr_ent;
    logic [7:0]       day_bits;
    logic             gate;
    logic             act;
    logic             change;
    logic             fit;
    logic             p_last;
    logic [CNT_W-1:0] p_plus1;
    logic             valid_up;
    logic             slot_free;

    assign rd_ent    = entry_t'(ram_rdata);
    assign day_bits  = {1'b0, rd_ent.days};
    assign p_plus1   = CNT_W'(p_idx_reg) + CNT_W'(1);
    assign p_last    = (p_plus1 == cnt_reg);
    assign slot_free = !out_valid_reg || rsp_ready;
    assign fit       = (ev_n_reg < EVC_W'(MAX_RESULTS));

    // window test, wrapping past midnight when start is after end
    always_comb
    begin
        if (rd_ent.start_minute <= rd_ent.end_minute)
        begin
            act = (item_reg.minute_of_day >= rd_ent.start_minute) &&
                  (item_reg.minute_of_day <  rd_ent.end_minute);
        end
        else
        begin
            act = (item_reg.minute_of_day >= rd_ent.start_minute) ||
                  (item_reg.minute_of_day <  rd_ent.end_minute);
        end
    end

    assign gate = rd_ent.enabled && day_bits[item_reg.weekday] &&
                  relay_ok(rd_ent.relay, present_reg) &&
                  item_reg.relay_auto_mask[rd_ent.relay];
    assign change = gate && (act != rd_ent.running);

    assign valid_up = relay_ok(item_reg.relay_id, present_reg) &&
                      (item_reg.day_mask != 7'd0) &&
                      (item_reg.start_minute <= LAST_MINUTE) &&
                      (item_reg.end_minute <= LAST_MINUTE);

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        cnt_next        = cnt_reg;
        issue_next      = issue_reg;
        pv_next         = 1'b0;
        p_idx_next      = p_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_run_next    = hit_run_reg;
        maxid_next      = maxid_reg;
        run_all_next    = run_all_reg;
        run_excl_next   = run_excl_reg;
        ev_n_next       = ev_n_reg;
        em_next         = em_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_any_next    = res_any_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_next        = out_reg;
        cmd_ready       = 1'b0;
        wr_ent          = rd_ent;
        ram_req.we      = 1'b0;
        ram_req.waddr   = p_idx_reg;
        ram_req.wdata   = ram_rdata;
        ram_req.raddr   = issue_reg[IDX_W-1:0];
        evq_req.push    = 1'b0;
        evq_req.pop     = 1'b0;
        evq_req.ev      = '{id: rd_ent.id, relay: rd_ent.relay, on: act};

        // read pipeline shared by table walk and compaction
        if (state_reg == S_SCAN || state_reg == S_SHIFT)
        begin
            if (issue_reg < cnt_reg)
            begin
                issue_next = issue_reg + CNT_W'(1);
                pv_next    = 1'b1;
                p_idx_next = issue_reg[IDX_W-1:0];
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    item_next     = cmd;
                    issue_next    = '0;
                    hit_next      = 1'b0;
                    hit_run_next  = 1'b0;
                    maxid_next    = 8'd0;
                    run_all_next  = 1'b0;
                    run_excl_next = 1'b0;
                    ev_n_next     = '0;
                    state_next    = (cnt_reg == '0) ? S_FIN : S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (pv_reg)
                begin
                    if (item_reg.mode == MODE_TICK)
                    begin
                        if (change && fit)
                        begin
                            wr_ent.running = act;
                            ram_req.we     = 1'b1;
                            ram_req.wdata  = wr_ent;
                            evq_req.push   = 1'b1;
                            ev_n_next      = ev_n_reg + EVC_W'(1);
                            run_all_next   = run_all_reg || act;
                        end
                        else
                        begin
                            run_all_next = run_all_reg || rd_ent.running;
                        end
                    end
                    else
                    begin
                        run_all_next = run_all_reg || rd_ent.running;
                        if (rd_ent.id == item_reg.entry_id)
                        begin
                            hit_next     = 1'b1;
                            hit_idx_next = p_idx_reg;
                            hit_run_next = rd_ent.running;
                        end
                        else
                        begin
                            run_excl_next = run_excl_reg || rd_ent.running;
                        end
                        if (rd_ent.id > maxid_reg)
                        begin
                            maxid_next = rd_ent.id;
                        end
                    end
                    if (p_last)
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            S_FIN:
            begin
                state_next      = S_RESP;
                res_any_next    = run_all_reg;
                res_id_next     = item_reg.entry_id;
                res_status_next = ST_DONE;
                wr_ent.relay        = item_reg.relay_id;
                wr_ent.days         = item_reg.day_mask;
                wr_ent.start_minute = item_reg.start_minute;
                wr_ent.end_minute   = item_reg.end_minute;
                wr_ent.enabled      = item_reg.entry_enabled;
                wr_ent.id           = item_reg.entry_id;
                wr_ent.running      = hit_run_reg;
                ram_req.wdata       = wr_ent;
                unique case (item_reg.mode)
                    MODE_TICK:
                    begin
                        res_id_next = 8'd0;
                        em_next     = '0;
                        if (ev_n_reg != '0)
                        begin
                            state_next = S_EMIT;
                        end
                    end
                    MODE_UPSERT:
                    begin
                        if (!valid_up)
                        begin
                            res_status_next = ST_INVALID;
                        end
                        else if (hit_reg)
                        begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = hit_idx_reg;
                        end
                        else if (cnt_reg >= CNT_W'(MAX_ENTRIES))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else if (maxid_reg == ID_LIMIT)
                        begin
                            res_status_next = ST_NOIDS;
                        end
                        else
                        begin
                            wr_ent.id      = maxid_reg + 8'd1;
                            wr_ent.running = 1'b0;
                            ram_req.wdata  = wr_ent;
                            ram_req.we     = 1'b1;
                            ram_req.waddr  = cnt_reg[IDX_W-1:0];
                            cnt_next       = cnt_reg + CNT_W'(1);
                            res_id_next    = maxid_reg + 8'd1;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (!hit_reg)
                        begin
                            res_status_next = ST_NOTFOUND;
                        end
                        else
                        begin
                            res_any_next = run_excl_reg;
                            if (CNT_W'(hit_idx_reg) + CNT_W'(1) == cnt_reg)
                            begin
                                cnt_next = cnt_reg - CNT_W'(1);
                            end
                            else
                            begin
                                issue_next = CNT_W'(hit_idx_reg) + CNT_W'(1);
                                state_next = S_SHIFT;
                            end
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_INVALID;
                    end
                endcase
            end

            S_SHIFT:
            begin
                // move entry p down by one slot
                if (pv_reg)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = p_idx_reg - IDX_W'(1);
                    ram_req.wdata = ram_rdata;
                    if (p_last)
                    begin
                        cnt_next   = cnt_reg - CNT_W'(1);
                        state_next = S_RESP;
                    end
                end
            end

            S_RESP:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{status: res_status_reg, result_id: res_id_reg,
                                       switch_relay: 4'd0, switch_on: 1'b0,
                                       any_running: res_any_reg, last: 1'b1};
                    state_next     = S_IDLE;
                end
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    evq_req.pop    = 1'b1;
                    out_valid_next = 1'b1;
                    em_next        = em_reg + EVC_W'(1);
                    out_next       = '{status: ST_SWITCH, result_id: evq_head.id,
                                       switch_relay: evq_head.relay, switch_on: evq_head.on,
                                       any_running: res_any_reg,
                                       last: (em_next == ev_n_reg)};
                    if (em_next == ev_n_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            ev_n_reg      <= '0;
            em_reg        <= '0;
            present_reg   <= 16'hFFFF;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
            ev_n_reg      <= ev_n_next;
            em_reg        <= em_next;
            if (cfg_we)
            begin
                present_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        issue_reg      <= issue_next;
        p_idx_reg      <= p_idx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_run_reg    <= hit_run_next;
        maxid_reg      <= maxid_next;
        run_all_reg    <= run_all_next;
        run_excl_reg   <= run_excl_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_any_reg    <= res_any_next;
        out_reg        <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count exceeds table depth");

    a_ev_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ev_n_reg <= EVC_W'(MAX_RESULTS))
        else $error("event count exceeds queue depth");

    a_scan_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && ram_req.we) |-> (item_reg.mode == MODE_TICK))
        else $error("table written during a non-tick walk");

    a_shift_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && pv_reg) |-> (p_idx_reg != '0))
        else $error("compaction would write below entry zero");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> (state_reg != S_IDLE))
        else $error("accepted transaction left the sequencer idle");

endmodule

`default_nettype wire

>>> rtl/weekly_window_relay_scheduler_top.sv
// Weekly window relay scheduler.
// Command channel (cmd_valid/cmd_ready/cmd) carries one transaction per item: a tick with
// the minute of day, weekday and relay auto mask, an upsert of a window entry, or a remove.
// Response channel (rsp_valid/rsp_ready/rsp) returns one transaction per upsert or remove,
// and one per relay switch event on a tick (up to 16), or a single done transaction when
// nothing switches; the final transaction of an item has last set, and all of them carry
// any_running as it stands once the item is complete.
// The window table lives in a single-port-read, single-port-write RAM with a registered
// read port; every item walks the stored entries at one entry per cycle, then passes a
// finish step, then, on a remove that leaves a gap, compacts the table by moving each
// later entry down one slot, and then hands out its result transactions.
// One item is worked on at a time.
// cfg_we/cfg_wdata write the relay present mask; write it only while the block is idle.
// Reset (rst_n low, asynchronous) empties the table and sets every relay present; the RAM
// contents are not cleared, since only entries below the count are ever read.
// A stalled receiver holds the result in the output register; the next command is still
// accepted once the current item has been handed to that register.
`default_nettype none

module weekly_window_relay_scheduler_top
    import wwrs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  wire cmd_t        cmd,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output rsp_t             rsp,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);

    ram_req_t           ram_req;
    logic [ENTRY_W-1:0] ram_rdata;
    evq_req_t           evq_req;
    ev_t                evq_head;

    // sequencer: walks the table, applies edits, drives the output register
    wwrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .evq_req   (evq_req),
        .evq_head  (evq_head)
    );

    // window entry table
    wwrs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // hold switch events until the walk finishes and any_running is known
    wwrs_evq u_evq (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (evq_req),
        .head  (evq_head)
    );

endmodule

`default_nettype wire
